// ===== rtl/core/brns_pkg.sv =====
package brns_pkg;

  localparam int unsigned REQ_W  = 22;
  localparam int unsigned CLK_W  = 26;
  localparam int unsigned IDX_W  = 5;
  localparam int unsigned RATE_W = 18;
  localparam int unsigned DIV_W  = 16;
  localparam int unsigned NUM_W  = 32;
  localparam int unsigned DEN_W  = 22;
  localparam int unsigned CNT_W  = 5;

  localparam logic [NUM_W-1:0] PERMILLE     = 32'd1000;
  localparam logic [CLK_W-1:0] CLK_HZ_RESET = 26'd18432000;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_BAD = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic load_req;
    logic err_diff;
    logic err_load;
    logic clk_load;
    logic div_step;
    logic advance;
    logic pick;
    logic emit_ok;
    logic emit_bad;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic req_zero;
    logic err_worse;
    logic last_entry;
  } stat_t;

  function automatic logic [RATE_W-1:0] rate_of(input logic [IDX_W-1:0] idx);
    logic [RATE_W-1:0] r;
    case (idx)
      5'd0:    r = 18'd50;
      5'd1:    r = 18'd75;
      5'd2:    r = 18'd110;
      5'd3:    r = 18'd150;
      5'd4:    r = 18'd300;
      5'd5:    r = 18'd600;
      5'd6:    r = 18'd1200;
      5'd7:    r = 18'd2400;
      5'd8:    r = 18'd4800;
      5'd9:    r = 18'd9600;
      5'd10:   r = 18'd14400;
      5'd11:   r = 18'd19200;
      5'd12:   r = 18'd28800;
      5'd13:   r = 18'd38400;
      5'd14:   r = 18'd57600;
      5'd15:   r = 18'd76800;
      5'd16:   r = 18'd115200;
      5'd17:   r = 18'd153600;
      5'd18:   r = 18'd230400;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/brns_ctrl.sv =====
module brns_ctrl
  import brns_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o,
  output logic  busy_o
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_CHECK    = 4'd1;
  localparam logic [3:0] S_ERR_DIFF = 4'd2;
  localparam logic [3:0] S_ERR_LOAD = 4'd3;
  localparam logic [3:0] S_ERR_DIV  = 4'd4;
  localparam logic [3:0] S_ERR_CMP  = 4'd5;
  localparam logic [3:0] S_CLK_LOAD = 4'd6;
  localparam logic [3:0] S_CLK_DIV  = 4'd7;
  localparam logic [3:0] S_EMIT_OK  = 4'd8;
  localparam logic [3:0] S_EMIT_BAD = 4'd9;

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_W - 1);

  logic [3:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load_req = 1'b1;
          state_d        = S_CHECK;
        end
      end
      S_CHECK: begin
        state_d = stat_i.req_zero ? S_EMIT_BAD : S_ERR_DIFF;
      end
      S_ERR_DIFF: begin
        cmd_o.err_diff = 1'b1;
        state_d        = S_ERR_LOAD;
      end
      S_ERR_LOAD: begin
        cmd_o.err_load = 1'b1;
        cnt_d          = '0;
        state_d        = S_ERR_DIV;
      end
      S_ERR_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == CNT_LAST) begin
          state_d = S_ERR_CMP;
        end
      end
      S_ERR_CMP: begin
        if (stat_i.err_worse || stat_i.last_entry) begin
          cmd_o.pick = 1'b1;
          state_d    = S_CLK_LOAD;
        end else begin
          cmd_o.advance = 1'b1;
          state_d       = S_ERR_DIFF;
        end
      end
      S_CLK_LOAD: begin
        cmd_o.clk_load = 1'b1;
        cnt_d          = '0;
        state_d        = S_CLK_DIV;
      end
      S_CLK_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == CNT_LAST) begin
          state_d = S_EMIT_OK;
        end
      end
      S_EMIT_OK: begin
        cmd_o.emit_ok = 1'b1;
        state_d       = S_IDLE;
      end
      S_EMIT_BAD: begin
        cmd_o.emit_bad = 1'b1;
        state_d        = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

  a_start_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (state_q == S_CHECK))
    else $error("accepted transaction did not leave idle");

  a_div_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLK_DIV && cnt_q == CNT_LAST) |=> (state_q == S_EMIT_OK))
    else $error("divisor division did not end in emit");

  a_emit_ok_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit_ok |-> $past(state_q == S_CLK_DIV))
    else $error("result emitted without a divisor division");

  a_bad_only_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHECK && !stat_i.req_zero) |=> (state_q == S_ERR_DIFF))
    else $error("nonzero request took the bad path");

endmodule

// ===== rtl/core/brns_dpath.sv =====
module brns_dpath
  import brns_pkg::*;
#(
  parameter int unsigned NUM_RATES = 19
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  output stat_t             stat_o,
  input  logic [REQ_W-1:0]  req_i,
  input  logic [CLK_W-1:0]  clk_hz_i,
  output logic              done_o,
  output logic              status_o,
  output logic [IDX_W-1:0]  rate_index_o,
  output logic [RATE_W-1:0] chosen_rate_o,
  output logic [DIV_W-1:0]  divisor_o,
  output logic              divisor_saturated_o
);

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_RATES - 1);

  logic [REQ_W-1:0]  req_q;
  logic [IDX_W-1:0]  idx_q;
  logic [REQ_W-1:0]  diff_q;
  logic [NUM_W-1:0]  best_q;
  logic [NUM_W-1:0]  quo_q;
  logic [DEN_W-1:0]  rem_q;
  logic [DEN_W-1:0]  den_q;
  logic [RATE_W-1:0] rate_q;
  logic [IDX_W-1:0]  sel_q;

  logic              done_q;
  logic              status_q;
  logic [IDX_W-1:0]  index_out_q;
  logic [RATE_W-1:0] rate_out_q;
  logic [DIV_W-1:0]  div_out_q;
  logic              sat_out_q;

  logic [RATE_W-1:0] rate_cur;
  logic [REQ_W-1:0]  rate_ext;
  logic [REQ_W-1:0]  diff_d;
  logic [NUM_W-1:0]  err_num;
  logic [NUM_W-1:0]  clk_num;
  logic [DEN_W:0]    rem_shift;
  logic              rem_ge;
  logic [DEN_W:0]    rem_sub;
  logic              sat;

  assign rate_cur = rate_of(idx_q);
  assign rate_ext = REQ_W'(rate_cur);
  assign diff_d   = (req_q >= rate_ext) ? (req_q - rate_ext) : (rate_ext - req_q);
  assign err_num  = (NUM_W'(diff_q) * PERMILLE) + NUM_W'(req_q[REQ_W-1:1]);
  assign clk_num  = NUM_W'(clk_hz_i) + NUM_W'({rate_q, 3'b000});

  // restoring divider, one quotient bit per step
  assign rem_shift = {rem_q, quo_q[NUM_W-1]};
  assign rem_ge    = (rem_shift >= {1'b0, den_q});
  assign rem_sub   = rem_shift - {1'b0, den_q};

  assign sat = (quo_q[NUM_W-1:DIV_W] != '0);

  assign stat_o.req_zero   = (req_q == '0);
  assign stat_o.err_worse  = (idx_q != '0) && (quo_q > best_q);
  assign stat_o.last_entry = (idx_q == IDX_LAST);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_q <= req_i;
      idx_q <= '0;
    end
    if (cmd_i.err_diff) begin
      diff_q <= diff_d;
    end
    if (cmd_i.err_load) begin
      quo_q <= err_num;
      rem_q <= '0;
      den_q <= req_q;
    end
    if (cmd_i.clk_load) begin
      quo_q <= clk_num;
      rem_q <= '0;
      den_q <= {rate_q, 4'b0000};
    end
    if (cmd_i.div_step) begin
      quo_q <= {quo_q[NUM_W-2:0], rem_ge};
      rem_q <= rem_ge ? rem_sub[DEN_W-1:0] : rem_shift[DEN_W-1:0];
    end
    if (cmd_i.advance) begin
      best_q <= quo_q;
      idx_q  <= idx_q + 1'b1;
    end
    if (cmd_i.pick) begin
      if (stat_o.err_worse) begin
        rate_q <= rate_of(idx_q - 1'b1);
        sel_q  <= idx_q;
      end else begin
        rate_q <= rate_cur;
        sel_q  <= idx_q + 1'b1;
      end
    end
    if (cmd_i.emit_ok) begin
      status_q    <= STATUS_OK;
      index_out_q <= sel_q;
      rate_out_q  <= rate_q;
      div_out_q   <= sat ? '1 : quo_q[DIV_W-1:0];
      sat_out_q   <= sat;
    end
    if (cmd_i.emit_bad) begin
      status_q    <= STATUS_BAD;
      index_out_q <= '0;
      rate_out_q  <= '0;
      div_out_q   <= '0;
      sat_out_q   <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.emit_ok | cmd_i.emit_bad;
    end
  end

  assign done_o              = done_q;
  assign status_o            = status_q;
  assign rate_index_o        = index_out_q;
  assign chosen_rate_o       = rate_out_q;
  assign divisor_o           = div_out_q;
  assign divisor_saturated_o = sat_out_q;

  a_bad_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && status_q == STATUS_BAD) |-> (index_out_q == '0 && rate_out_q == '0))
    else $error("bad transaction carries a rate");

  a_ok_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && status_q == STATUS_OK) |-> (index_out_q != '0 && index_out_q <= IDX_LAST + 1'b1))
    else $error("chosen index out of table range");

  a_sat_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && sat_out_q) |-> (div_out_q == '1))
    else $error("saturated divisor not at full scale");

endmodule

// ===== rtl/core/baud_rate_nearest_select.sv =====
// channel     | ports                                        | handshake
// ------------+----------------------------------------------+-----------------------------
// request     | requested_rate_i                             | start & !busy
// result      | status_o rate_index_o chosen_rate_o          | done_o, one cycle, no stall
//             | divisor_o divisor_saturated_o                |
// config      | psel penable pwrite paddr pwdata prdata      | psel & penable & pwrite
//
// check; per entry visited: diff, load, divide, compare; then load, divide divisor, emit
// the error and divisor divisions share one restoring divider at one quotient bit a cycle
// a zero request skips both divisions and goes from the check state to the bad emit
// reset is asynchronous active low and loads the clock register with 18432000
// done_o rises the cycle busy drops; results cannot be held off
module baud_rate_nearest_select
  import brns_pkg::*;
#(
  parameter int unsigned NUM_RATES = 19
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [REQ_W-1:0]  requested_rate_i,
  output logic              done_o,
  output logic              status_o,
  output logic [IDX_W-1:0]  rate_index_o,
  output logic [RATE_W-1:0] chosen_rate_o,
  output logic [DIV_W-1:0]  divisor_o,
  output logic              divisor_saturated_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam logic REG_CLK_HZ = 1'b0;

  cmd_t             cmd;
  stat_t            stat;
  logic [CLK_W-1:0] clk_hz_q;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clk_hz_q <= CLK_HZ_RESET;
    end else if (cfg_wr && paddr[2] == REG_CLK_HZ) begin
      clk_hz_q <= pwdata[CLK_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_CLK_HZ) ? 32'(clk_hz_q) : '0;

  brns_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start && !busy),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy_o (busy)
  );

  brns_dpath #(
    .NUM_RATES(NUM_RATES)
  ) u_dpath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .stat_o             (stat),
    .req_i              (requested_rate_i),
    .clk_hz_i           (clk_hz_q),
    .done_o             (done_o),
    .status_o           (status_o),
    .rate_index_o       (rate_index_o),
    .chosen_rate_o      (chosen_rate_o),
    .divisor_o          (divisor_o),
    .divisor_saturated_o(divisor_saturated_o)
  );

endmodule
